// ----- src/dht_pkg.sv -----
// Shared widths and codes for the double-hashing key-value table.
package dht_pkg;

  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int PC_W   = 10;
  localparam int SLOT_W = 2;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] RES_OK      = 2'd0;
  localparam logic [STAT_W-1:0] RES_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] RES_MISSING = 2'd2;

  localparam logic [SLOT_W-1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_USED    = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_DELETED = 2'd2;

endpackage

// ----- src/dht_ram.sv -----
// Generic simple dual-port RAM with registered read.
module dht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/dht_hash.sv -----
// Remainder unit: home slot and probe stride of a key by reciprocal multiplication.
module dht_hash #(
  parameter int SLOTS = 1021
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [dht_pkg::KEY_W-1:0]    key,
  output logic                         done,
  output logic [$clog2(SLOTS)-1:0]     first,
  output logic [$clog2(SLOTS)-1:0]     stride
);

  localparam int IW   = $clog2(SLOTS);
  localparam int MW   = 32;
  localparam int SH_A = dht_pkg::KEY_W + $clog2(SLOTS);
  localparam int SH_B = dht_pkg::KEY_W + $clog2(SLOTS - 1);
  localparam logic [MW-1:0] RCP_A =
    MW'(((64'd1 << SH_A) + 64'(SLOTS - 1)) / 64'(SLOTS));
  localparam logic [MW-1:0] RCP_B =
    MW'(((64'd1 << SH_B) + 64'(SLOTS - 2)) / 64'(SLOTS - 1));

  typedef enum logic [5:0] {
    H_IDLE  = 6'b000001,
    H_RCPA  = 6'b000010,
    H_RCPB  = 6'b000100,
    H_BACKA = 6'b001000,
    H_BACKB = 6'b010000,
    H_LAST  = 6'b100000
  } hash_state_t;

  hash_state_t               hstate;
  logic [dht_pkg::KEY_W-1:0] key_q;
  logic [MW-1:0]             quo_a;
  logic [MW-1:0]             quo_b;
  logic [MW-1:0]             mul_a;
  logic [MW-1:0]             mul_b;
  logic [2*MW-1:0]           prod;
  logic [2*MW-1:0]           prod_next;
  logic [MW-1:0]             rem_next;
  logic [IW-1:0]             ra;
  logic [IW-1:0]             rb;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (hstate)
      H_RCPA: begin
        mul_a = MW'(key_q);
        mul_b = RCP_A;
      end
      H_RCPB: begin
        mul_a = MW'(key_q);
        mul_b = RCP_B;
      end
      H_BACKA: begin
        mul_a = quo_a;
        mul_b = MW'(SLOTS);
      end
      H_BACKB: begin
        mul_a = quo_b;
        mul_b = MW'(SLOTS - 1);
      end
      default: begin
      end
    endcase
    prod_next = mul_a * mul_b;
    rem_next  = MW'(key_q) - prod[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hstate <= H_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (hstate)
        H_IDLE: begin
          if (start) begin
            hstate <= H_RCPA;
          end
        end
        H_RCPA: begin
          hstate <= H_RCPB;
        end
        H_RCPB: begin
          hstate <= H_BACKA;
        end
        H_BACKA: begin
          hstate <= H_BACKB;
        end
        H_BACKB: begin
          hstate <= H_LAST;
        end
        H_LAST: begin
          hstate <= H_IDLE;
          done   <= 1'b1;
        end
        default: begin
          hstate <= H_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && hstate == H_IDLE) begin
      key_q <= key;
    end
    prod <= prod_next;
    if (hstate == H_RCPB) begin
      quo_a <= MW'(prod >> SH_A);
    end
    if (hstate == H_BACKA) begin
      quo_b <= MW'(prod >> SH_B);
    end
    if (hstate == H_BACKB) begin
      ra <= IW'(rem_next);
    end
    if (hstate == H_LAST) begin
      rb <= IW'(rem_next);
    end
  end

  assign first  = ra;
  assign stride = rb + 1'b1;

endmodule

// ----- src/double_hash_table.sv -----
// Top level of the open-addressing key-value table with double hashing.
// After reset the block sweeps the slot status memory to empty, one slot per
// cycle, with busy high. An item is taken when start is high and busy is low;
// for a hashed item busy then stays high until the result. Insert, search and
// delete first find the home slot and stride of the key on one shared
// multiplier by reciprocal multiplication and back-multiplication, then walk
// the probe sequence, each probe passing through S_PROBE and S_CHECK for the
// registered read of the slot memories; the index of the last probe is at
// most SLOTS-1. An insert into a full table and an unknown action answer in
// the cycle after acceptance. Each result is held for exactly one cycle with
// done high and must be taken then; busy falls in that same cycle.
module double_hash_table #(
  parameter int SLOTS = 1021
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [dht_pkg::ACT_W-1:0]          action,
  input  logic [dht_pkg::KEY_W-1:0]          key_in,
  input  logic signed [dht_pkg::VAL_W-1:0]   value_in,
  output logic                               done,
  output logic [dht_pkg::STAT_W-1:0]         status,
  output logic signed [dht_pkg::VAL_W-1:0]   value_out,
  output logic [dht_pkg::PC_W-1:0]           probe_count
);

  localparam int IW  = $clog2(SLOTS);
  localparam int UCW = $clog2(SLOTS + 1);
  localparam int KVW = dht_pkg::KEY_W + dht_pkg::VAL_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_PROBE = 5'b01000,
    S_CHECK = 5'b10000
  } state_t;

  state_t state;

  logic [dht_pkg::ACT_W-1:0]  act;
  logic [dht_pkg::KEY_W-1:0]  key;
  logic [dht_pkg::VAL_W-1:0]  val;
  logic [IW-1:0]              pos;
  logic [IW-1:0]              step;
  logic [IW-1:0]              idx;
  logic [UCW-1:0]             used_count;

  logic                       accept;
  logic                       hash_start;
  logic                       hash_done;
  logic [IW-1:0]              hash_first;
  logic [IW-1:0]              hash_stride;

  logic                       st_we;
  logic [dht_pkg::SLOT_W-1:0] st_wdata;
  logic [dht_pkg::SLOT_W-1:0] st_q;
  logic                       kv_we;
  logic [KVW-1:0]             kv_q;

  logic [IW:0]                pos_sum;
  logic [IW-1:0]              pos_next;
  logic                       slot_empty;
  logic                       slot_hit;
  logic                       last_probe;
  logic                       table_full;
  logic                       act_known;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign table_full = (used_count == UCW'(SLOTS));
  assign act_known  = (action == dht_pkg::ACT_INSERT) || (action == dht_pkg::ACT_SEARCH) ||
                      (action == dht_pkg::ACT_DELETE);
  assign hash_start = accept && act_known &&
                      !(action == dht_pkg::ACT_INSERT && table_full);

  assign pos_sum    = {1'b0, pos} + {1'b0, step};
  assign pos_next   = (pos_sum >= (IW+1)'(SLOTS)) ? IW'(pos_sum - (IW+1)'(SLOTS)) : IW'(pos_sum);
  assign slot_empty = (st_q == dht_pkg::SLOT_EMPTY);
  assign slot_hit   = (st_q == dht_pkg::SLOT_USED) &&
                      (kv_q[KVW-1:dht_pkg::VAL_W] == key);
  assign last_probe = (idx == IW'(SLOTS - 1));

  always_comb begin
    st_we    = 1'b0;
    st_wdata = dht_pkg::SLOT_EMPTY;
    kv_we    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        st_we = 1'b1;
      end
      S_CHECK: begin
        if (act == dht_pkg::ACT_INSERT && slot_empty) begin
          st_we    = 1'b1;
          st_wdata = dht_pkg::SLOT_USED;
          kv_we    = 1'b1;
        end else if (act == dht_pkg::ACT_DELETE && !slot_empty && slot_hit) begin
          st_we    = 1'b1;
          st_wdata = dht_pkg::SLOT_DELETED;
        end
      end
      default: begin
      end
    endcase
  end

  dht_hash #(
    .SLOTS(SLOTS)
  ) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .key    (key_in),
    .done   (hash_done),
    .first  (hash_first),
    .stride (hash_stride)
  );

  dht_ram #(
    .WIDTH(dht_pkg::SLOT_W),
    .DEPTH(SLOTS)
  ) u_status_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (pos),
    .wdata (st_wdata),
    .raddr (pos),
    .rdata (st_q)
  );

  dht_ram #(
    .WIDTH(KVW),
    .DEPTH(SLOTS)
  ) u_kv_ram (
    .clk   (clk),
    .we    (kv_we),
    .waddr (pos),
    .wdata ({key, val}),
    .raddr (pos),
    .rdata (kv_q)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      pos        <= '0;
      used_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (pos == IW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (hash_start) begin
              state <= S_HASH;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            pos   <= hash_first;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          priority if (act == dht_pkg::ACT_INSERT && slot_empty) begin
            used_count <= used_count + 1'b1;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else if (act != dht_pkg::ACT_INSERT && (slot_empty || slot_hit)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (last_probe) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            pos   <= pos_next;
            state <= S_PROBE;
          end
        end
        default: begin
          state <= S_CLEAR;
          pos   <= '0;
        end
      endcase
    end
  end

  // operands and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      act <= action;
      key <= key_in;
      val <= value_in;
      status      <= (action == dht_pkg::ACT_INSERT) ? dht_pkg::RES_FULL
                                                     : dht_pkg::RES_MISSING;
      value_out   <= '0;
      probe_count <= '0;
    end
    if (state == S_HASH && hash_done) begin
      step <= hash_stride;
      idx  <= '0;
    end
    if (state == S_CHECK) begin
      priority if (act == dht_pkg::ACT_INSERT && slot_empty) begin
        status      <= dht_pkg::RES_OK;
        probe_count <= dht_pkg::PC_W'(idx);
      end else if (act != dht_pkg::ACT_INSERT && slot_empty) begin
        status <= dht_pkg::RES_MISSING;
      end else if (act != dht_pkg::ACT_INSERT && slot_hit) begin
        status <= dht_pkg::RES_OK;
        if (act == dht_pkg::ACT_SEARCH) begin
          value_out <= signed'(kv_q[dht_pkg::VAL_W-1:0]);
        end
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= UCW'(SLOTS))
    else $error("used slot count exceeds table size");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    st_we |-> (state == S_CLEAR || state == S_CHECK))
    else $error("slot status written outside clear pass or check");

  a_hash_state: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> (state == S_HASH))
    else $error("hash result arrived outside hash wait");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (done && act == dht_pkg::ACT_INSERT && status == dht_pkg::RES_OK && !$past(rst))
      |-> (used_count == $past(used_count) + 1'b1))
    else $error("successful insert did not advance used slot count");

endmodule

// ----- bench/double_hash_table_checker.sv -----
// Checker for the hash table: models the slot store, predicts each reply and compares.
`timescale 1ns / 100ps

module double_hash_table_checker
  import dht_pkg::*;
#(
  parameter int SLOTS = 1021
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic [ACT_W-1:0]         action,
  input  logic [KEY_W-1:0]         key_in,
  input  logic signed [VAL_W-1:0]  value_in,
  input  logic                     done,
  input  logic [STAT_W-1:0]        status,
  input  logic signed [VAL_W-1:0]  value_out,
  input  logic [PC_W-1:0]          probe_count,
  output int                       mismatches,
  output int                       replies_due
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  value;
    logic [PC_W-1:0]   probes;
  } table_reply_t;

  logic [SLOT_W-1:0] slot_state [SLOTS];
  logic [KEY_W-1:0]  slot_keys  [SLOTS];
  logic [VAL_W-1:0]  slot_vals  [SLOTS];
  int unsigned       fill_count;
  table_reply_t      reply_q [$];

  function automatic int unsigned lookup_slot(logic [KEY_W-1:0] key);
    int unsigned k;
    int unsigned pos;
    int unsigned stride;
    int unsigned hit;
    k = key;
    pos = k % SLOTS;
    stride = 1 + k % (SLOTS - 1);
    hit = SLOTS;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit == SLOTS && slot_state[pos] == SLOT_EMPTY) begin
        break;
      end
      if (slot_state[pos] == SLOT_USED && slot_keys[pos] == key) begin
        hit = pos;
        break;
      end
      pos = (pos + stride) % SLOTS;
    end
    return hit;
  endfunction

  function automatic table_reply_t apply_op(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key,
                                            logic [VAL_W-1:0] val);
    table_reply_t r;
    int unsigned  k;
    int unsigned  pos;
    int unsigned  stride;
    bit           placed;
    r.status = RES_MISSING;
    r.value  = '0;
    r.probes = '0;
    case (act)
      ACT_INSERT: begin
        r.status = RES_FULL;
        if (fill_count < SLOTS) begin
          k = key;
          pos = k % SLOTS;
          stride = 1 + k % (SLOTS - 1);
          placed = 1'b0;
          for (int i = 0; i < SLOTS && !placed; i++) begin
            if (slot_state[pos] == SLOT_EMPTY) begin
              slot_state[pos] = SLOT_USED;
              slot_keys[pos]  = key;
              slot_vals[pos]  = val;
              fill_count++;
              r.status = RES_OK;
              r.probes = PC_W'(i);
              placed = 1'b1;
            end else begin
              pos = (pos + stride) % SLOTS;
            end
          end
        end
      end
      ACT_SEARCH: begin
        pos = lookup_slot(key);
        if (pos < SLOTS) begin
          r.status = RES_OK;
          r.value  = slot_vals[pos];
        end
      end
      ACT_DELETE: begin
        pos = lookup_slot(key);
        if (pos < SLOTS) begin
          slot_state[pos] = SLOT_DELETED;
          r.status = RES_OK;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    table_reply_t want;
    int           bad;
    bad = 0;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_state[i] = SLOT_EMPTY;
      fill_count = 0;
      reply_q.delete();
      replies_due <= 0;
      mismatches  <= 0;
    end else begin
      if (done) begin
        if (reply_q.size() == 0) begin
          $error("unexpected result: status %0d, value_out %0d, probe_count %0d",
                 status, value_out, probe_count);
          bad++;
        end else begin
          want = reply_q.pop_front();
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            bad++;
          end
          if (value_out !== want.value) begin
            $error("value_out mismatch: expected %0d, actual %0d",
                   $signed(want.value), value_out);
            bad++;
          end
          if (probe_count !== want.probes) begin
            $error("probe_count mismatch: expected %0d, actual %0d",
                   want.probes, probe_count);
            bad++;
          end
        end
      end
      if (start && !busy) reply_q.push_back(apply_op(action, key_in, value_in));
      replies_due <= reply_q.size();
      mismatches  <= mismatches + bad;
    end
  end

endmodule

// ----- bench/double_hash_table_tb.sv -----
// Testbench top for the hash table: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module double_hash_table_tb;
  import dht_pkg::*;

  localparam int SLOTS = 1021;
  localparam int CHAIN_STEP = SLOTS * (SLOTS - 1);
  localparam int PHASE_ITEMS = 360;
  localparam logic [ACT_W-1:0] ACT_BOGUS = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [ACT_W-1:0]        action = ACT_INSERT;
  logic [KEY_W-1:0]        key_in = '0;
  logic signed [VAL_W-1:0] value_in = '0;
  logic                    done;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] value_out;
  logic [PC_W-1:0]         probe_count;
  int                      mismatches;
  int                      replies_due;

  int                      sender_idle = 0;
  int unsigned             inserts_sent = 0;
  logic [KEY_W-1:0]        stored_keys [$];
  int                      idle_by_phase [4] = '{0, 73, 0, 28};

  double_hash_table #(.SLOTS(SLOTS)) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .key_in      (key_in),
    .value_in    (value_in),
    .done        (done),
    .status      (status),
    .value_out   (value_out),
    .probe_count (probe_count)
  );

  double_hash_table_checker #(.SLOTS(SLOTS)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .key_in      (key_in),
    .value_in    (value_in),
    .done        (done),
    .status      (status),
    .value_out   (value_out),
    .probe_count (probe_count),
    .mismatches  (mismatches),
    .replies_due (replies_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_word(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val);
    if (sender_idle > 0 && $urandom_range(1) == 1) begin
      start <= 1'b0;
      do @(posedge clk); while (busy);
    end
    while ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    if (act == ACT_INSERT) begin
      inserts_sent++;
      stored_keys.push_back(key);
    end
    start    <= 1'b1;
    action   <= act;
    key_in   <= key;
    value_in <= val;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    do @(posedge clk); while (replies_due != 0);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45 && stored_keys.size() > 0)
      return stored_keys[$urandom_range(stored_keys.size() - 1)];
    if (r < 70)
      return KEY_W'($urandom_range(3) * 37 + $urandom_range(7) * CHAIN_STEP);
    if (r < 80)
      return KEY_W'($urandom_range(3 * SLOTS));
    return KEY_W'($urandom());
  endfunction

  task automatic random_item();
    int unsigned      r;
    logic [ACT_W-1:0] act;
    r = $urandom_range(99);
    if (r < 40)      act = ACT_INSERT;
    else if (r < 70) act = ACT_SEARCH;
    else if (r < 97) act = ACT_DELETE;
    else             act = ACT_BOGUS;
    send_word(act, pick_key(), $urandom());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    // extremes, duplicates, deleted-slot skipping and unknown action
    send_word(ACT_INSERT, '0, 32'h8000_0000);
    send_word(ACT_INSERT, '1, 32'h7fff_ffff);
    send_word(ACT_SEARCH, '0, $urandom());
    send_word(ACT_SEARCH, '1, $urandom());
    send_word(ACT_SEARCH, KEY_W'(5), $urandom());
    send_word(ACT_INSERT, '0, 32'd1);
    send_word(ACT_SEARCH, '0, $urandom());
    send_word(ACT_DELETE, '0, $urandom());
    send_word(ACT_SEARCH, '0, $urandom());
    send_word(ACT_DELETE, '0, $urandom());
    send_word(ACT_DELETE, '0, $urandom());
    send_word(ACT_INSERT, KEY_W'(CHAIN_STEP), 32'h0000_0000);
    send_word(ACT_SEARCH, KEY_W'(CHAIN_STEP), $urandom());
    send_word(ACT_BOGUS, KEY_W'($urandom()), $urandom());
    send_word(ACT_BOGUS, '1, '1);
    send_word(ACT_INSERT, KEY_W'(2 * CHAIN_STEP), 32'hffff_ffff);
    send_word(ACT_DELETE, KEY_W'(CHAIN_STEP), $urandom());
    send_word(ACT_SEARCH, KEY_W'(2 * CHAIN_STEP), $urandom());
    send_word(ACT_DELETE, '1, $urandom());
    send_word(ACT_SEARCH, '1, $urandom());
    drain_replies();

    foreach (idle_by_phase[p]) begin
      sender_idle = idle_by_phase[p];
      repeat (PHASE_ITEMS) random_item();
      drain_replies();
    end

    // fill to capacity, then full inserts and probe-limited lookups
    sender_idle = 0;
    while (inserts_sent < SLOTS) send_word(ACT_INSERT, KEY_W'($urandom()), $urandom());
    send_word(ACT_INSERT, KEY_W'($urandom()), $urandom());
    send_word(ACT_SEARCH, KEY_W'($urandom()), $urandom());
    send_word(ACT_DELETE, KEY_W'($urandom()), $urandom());
    send_word(ACT_SEARCH, stored_keys[$urandom_range(stored_keys.size() - 1)], $urandom());
    send_word(ACT_DELETE, stored_keys[$urandom_range(stored_keys.size() - 1)], $urandom());
    send_word(ACT_INSERT, '1, '1);
    send_word(ACT_SEARCH, KEY_W'($urandom()), $urandom());
    send_word(ACT_BOGUS, KEY_W'($urandom()), $urandom());
    drain_replies();
    repeat (64) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
